// File: src/call_duration_profiler_top_defines.svh
// Assertion macros shared by the call duration profiler RTL.
`ifndef CALL_DURATION_PROFILER_TOP_DEFINES_SVH
`define CALL_DURATION_PROFILER_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CDP_ASSERT_NOW(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CDP_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: src/cdp_pkg.sv
// Shared types and constants of the call duration profiler.
package cdp_pkg;

   localparam int MAX_CALLS   = 256;
   localparam int STACK_DEPTH = 32;
   localparam int ID_AW       = (MAX_CALLS > 1) ? $clog2(MAX_CALLS) : 1;
   localparam int STK_AW      = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

   localparam logic [31:0] MIN_INIT         = 32'hEFFF_FFFF;
   localparam logic [26:0] TICKS_PER_MINUTE = 27'(60 * 1000000);

   typedef enum logic [1:0] {
      ACT_ENTER = 2'd0,
      ACT_EXIT  = 2'd1,
      ACT_READ  = 2'd2,
      ACT_CLEAR = 2'd3
   } action_type;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_EMPTY     = 3'd1,
      ST_WRONG     = 3'd2,
      ST_FULL      = 3'd3,
      ST_NOT_FOUND = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      CS_IDLE,
      CS_EXEC,
      CS_POP
   } ctrl_state_type;

   typedef struct packed {
      logic [1:0]  action;
      logic [7:0]  call_id;
      logic        exit_named;
      logic [25:0] time_now;
   } req_item_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [7:0]  entry_id;
      logic [31:0] call_count;
      logic [31:0] total_time;
      logic [31:0] min_time;
      logic [25:0] max_time;
      logic [25:0] last_duration;
      logic [5:0]  stack_depth;
   } rsp_item_type;

   typedef struct packed {
      logic accept;
      logic pop_rd;
      logic commit;
   } ctrl_cmd_type;

   typedef struct packed {
      logic need_pop;
      logic out_free;
   } dp_status_type;

endpackage

// File: src/cdp_ctrl.sv
// Sequencing state machine of the call duration profiler.
module cdp_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  cdp_pkg::dp_status_type status,
   output cdp_pkg::ctrl_cmd_type  cmd
);
   import cdp_pkg::*;

   ctrl_state_type state_ff;
   ctrl_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CS_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      unique case (state_ff)
         CS_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = CS_EXEC;
            end
         end
         CS_EXEC: begin
            if (status.need_pop) begin
               cmd.pop_rd = 1'b1;
               state_in   = CS_POP;
            end else if (status.out_free) begin
               cmd.commit = 1'b1;
               state_in   = CS_IDLE;
            end
         end
         CS_POP: begin
            if (status.out_free) begin
               cmd.commit = 1'b1;
               state_in   = CS_IDLE;
            end
         end
         default: begin
            state_in = CS_IDLE;
         end
      endcase
   end

   assign req_stall = (state_ff != CS_IDLE);

endmodule

// File: src/cdp_datapath.sv
// Statistics memories, call stack and result register of the profiler.
module cdp_datapath (
   input  logic                  clock,
   input  logic                  reset,
   input  cdp_pkg::ctrl_cmd_type  cmd,
   output cdp_pkg::dp_status_type status,
   input  cdp_pkg::req_item_type  req_item,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output cdp_pkg::rsp_item_type  rsp_item
);
   import cdp_pkg::*;
   `include "call_duration_profiler_top_defines.svh"

   // Statistics memories, one entry per identifier.
   logic [31:0] count_mem [MAX_CALLS];
   logic [31:0] total_mem [MAX_CALLS];
   logic [31:0] min_mem   [MAX_CALLS];
   logic [25:0] max_mem   [MAX_CALLS];

   // Call stack memories.
   logic [7:0]  stk_id_mem   [STACK_DEPTH];
   logic [25:0] stk_time_mem [STACK_DEPTH];

   req_item_type item_ff;
   logic [31:0]  count_rd_ff;
   logic [31:0]  total_rd_ff;
   logic [31:0]  min_rd_ff;
   logic [25:0]  max_rd_ff;
   logic [7:0]   stk_id_rd_ff;
   logic [25:0]  stk_time_rd_ff;
   logic [25:0]  dur_ff;
   logic         pop_pend_ff;
   logic         pop_pend_in;
   logic [5:0]   sp_ff;
   logic [5:0]   sp_in;
   logic [MAX_CALLS-1:0] known_ff;
   logic [MAX_CALLS-1:0] known_in;
   logic         rsp_valid_ff;
   logic         rsp_valid_in;
   rsp_item_type rsp_data_ff;
   rsp_item_type rsp_data_in;

   logic [ID_AW-1:0] id_idx;
   logic [ID_AW-1:0] tid_idx;
   logic [ID_AW-1:0] tbl_ra;
   logic [ID_AW-1:0] tbl_wa;
   logic             tbl_re;
   logic             tbl_we;
   logic [31:0]      new_count;
   logic [31:0]      new_total;
   logic [31:0]      new_min;
   logic [25:0]      new_max;
   logic             push;
   logic             in_table;
   logic             known_id;
   logic             stk_empty;
   logic             wrong_call;
   logic [26:0]      dur_wide;
   logic [25:0]      dur_in;

   assign id_idx    = ID_AW'(item_ff.call_id);
   assign tid_idx   = ID_AW'(stk_id_rd_ff);
   assign in_table  = int'(item_ff.call_id) < MAX_CALLS;
   assign known_id  = in_table && known_ff[id_idx];
   assign stk_empty = (sp_ff == 6'd0) || (int'(sp_ff) > STACK_DEPTH);
   assign wrong_call = item_ff.exit_named && known_id && (stk_id_rd_ff != item_ff.call_id);

   assign status.need_pop = (item_ff.action == ACT_EXIT) && !stk_empty && !wrong_call;
   assign status.out_free = !rsp_valid_ff || !rsp_stall;

   // Wrapped duration of the entry on top of the stack.
   always_comb begin
      if (item_ff.time_now < stk_time_rd_ff) begin
         dur_wide = {1'b0, item_ff.time_now} + TICKS_PER_MINUTE - {1'b0, stk_time_rd_ff};
      end else begin
         dur_wide = {1'b0, item_ff.time_now} - {1'b0, stk_time_rd_ff};
      end
      dur_in = dur_wide[25:0];
   end

   assign tbl_re = cmd.accept || cmd.pop_rd;
   assign tbl_ra = cmd.pop_rd ? tid_idx : ID_AW'(req_item.call_id);

   always_comb begin
      tbl_we      = 1'b0;
      tbl_wa      = id_idx;
      new_count   = count_rd_ff;
      new_total   = total_rd_ff;
      new_min     = min_rd_ff;
      new_max     = max_rd_ff;
      push        = 1'b0;
      sp_in       = sp_ff;
      known_in    = known_ff;
      pop_pend_in = pop_pend_ff;
      rsp_data_in = '0;

      if (cmd.pop_rd) begin
         pop_pend_in = 1'b1;
      end

      if (cmd.commit) begin
         pop_pend_in = 1'b0;
         unique case (item_ff.action)
            ACT_ENTER: begin
               rsp_data_in.entry_id = item_ff.call_id;
               if (!in_table) begin
                  rsp_data_in.status = ST_NOT_FOUND;
               end else begin
                  tbl_we    = 1'b1;
                  new_count = (known_id ? count_rd_ff : 32'd0) + 32'd1;
                  new_total = known_id ? total_rd_ff : 32'd0;
                  new_min   = known_id ? min_rd_ff : MIN_INIT;
                  new_max   = known_id ? max_rd_ff : 26'd0;
                  known_in[id_idx] = 1'b1;
                  if (int'(sp_ff) >= STACK_DEPTH) begin
                     rsp_data_in.status = ST_FULL;
                  end else begin
                     push  = 1'b1;
                     sp_in = sp_ff + 6'd1;
                     rsp_data_in.status = ST_OK;
                  end
                  rsp_data_in.call_count = new_count;
                  rsp_data_in.total_time = new_total;
                  rsp_data_in.min_time   = new_min;
                  rsp_data_in.max_time   = new_max;
               end
            end
            ACT_EXIT: begin
               if (pop_pend_ff) begin
                  tbl_we    = 1'b1;
                  tbl_wa    = tid_idx;
                  new_min   = (min_rd_ff > 32'(dur_ff)) ? 32'(dur_ff) : min_rd_ff;
                  new_max   = (max_rd_ff < dur_ff) ? dur_ff : max_rd_ff;
                  new_total = total_rd_ff + 32'(dur_ff);
                  sp_in     = sp_ff - 6'd1;
                  rsp_data_in.status        = ST_OK;
                  rsp_data_in.entry_id      = stk_id_rd_ff;
                  rsp_data_in.call_count    = count_rd_ff;
                  rsp_data_in.total_time    = new_total;
                  rsp_data_in.min_time      = new_min;
                  rsp_data_in.max_time      = new_max;
                  rsp_data_in.last_duration = dur_ff;
               end else begin
                  rsp_data_in.status = stk_empty ? ST_EMPTY : ST_WRONG;
               end
            end
            ACT_READ: begin
               rsp_data_in.entry_id = item_ff.call_id;
               if (known_id) begin
                  rsp_data_in.status     = ST_OK;
                  rsp_data_in.call_count = count_rd_ff;
                  rsp_data_in.total_time = total_rd_ff;
                  rsp_data_in.min_time   = min_rd_ff;
                  rsp_data_in.max_time   = max_rd_ff;
               end else begin
                  rsp_data_in.status = ST_NOT_FOUND;
               end
            end
            ACT_CLEAR: begin
               known_in = '0;
               sp_in    = 6'd0;
               rsp_data_in.status = ST_OK;
            end
            default: begin
               rsp_data_in.status = ST_OK;
            end
         endcase
         rsp_data_in.stack_depth = sp_in;
      end
   end

   always_comb begin
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_stall) begin
         rsp_valid_in = rsp_valid_ff;
      end else begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         sp_ff        <= 6'd0;
         known_ff     <= '0;
         pop_pend_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         sp_ff        <= sp_in;
         known_ff     <= known_in;
         pop_pend_ff  <= pop_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         item_ff        <= req_item;
         stk_id_rd_ff   <= stk_id_mem[STK_AW'(sp_ff - 6'd1)];
         stk_time_rd_ff <= stk_time_mem[STK_AW'(sp_ff - 6'd1)];
      end
      if (cmd.pop_rd) begin
         dur_ff <= dur_in;
      end
      if (cmd.commit) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   // Statistics memories: one read port, one write port.
   always_ff @(posedge clock) begin
      if (tbl_re) begin
         count_rd_ff <= count_mem[tbl_ra];
         total_rd_ff <= total_mem[tbl_ra];
         min_rd_ff   <= min_mem[tbl_ra];
         max_rd_ff   <= max_mem[tbl_ra];
      end
      if (tbl_we) begin
         count_mem[tbl_wa] <= new_count;
         total_mem[tbl_wa] <= new_total;
         min_mem[tbl_wa]   <= new_min;
         max_mem[tbl_wa]   <= new_max;
      end
   end

   // Stack memories.
   always_ff @(posedge clock) begin
      if (push) begin
         stk_id_mem[STK_AW'(sp_ff)]   <= item_ff.call_id;
         stk_time_mem[STK_AW'(sp_ff)] <= item_ff.time_now;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_data_ff;

   `CDP_ASSERT_NOW(a_sp_range, clock, reset, 1'b1, int'(sp_ff) <= STACK_DEPTH, "stack pointer beyond depth")
   `CDP_ASSERT_NOW(a_no_overwrite, clock, reset, cmd.commit, !(rsp_valid_ff && rsp_stall), "result overwritten while stalled")
   `CDP_ASSERT_NEXT(a_pop_dec, clock, reset, cmd.commit && pop_pend_ff, sp_ff == $past(sp_ff) - 6'd1, "pop did not lower the stack pointer")
   `CDP_ASSERT_NEXT(a_clear_empty, clock, reset, cmd.commit && (item_ff.action == ACT_CLEAR), (sp_ff == 6'd0) && (known_ff == '0), "clear left state behind")

endmodule

// File: src/call_duration_profiler_top.sv
// Top level of the call duration profiler: controller plus datapath.
// Enter, read, clear and a refused exit commit their result from the EXEC state, and
// an exit that pops goes on through the POP state first; each commit waits while
// a result is held downstream. A new item is taken only after the last one commits,
// since the chained stack and statistics reads use the single statistics read port.
// Reset is synchronous and active high and clears the control state; no clearing pass.
module call_duration_profiler_top (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  cdp_pkg::req_item_type req_item,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output cdp_pkg::rsp_item_type rsp_item
);
   import cdp_pkg::*;

   // The controller only sequences the work; all state that an item reads or changes
   // lives in the datapath. The two talk through one command and one status struct.
   ctrl_cmd_type  cmd;
   dp_status_type status;

   // An item is taken only in the idle state. The statistics and the stack top are read
   // at the acceptance edge. In the following cycle the datapath decides the outcome:
   // an exit that pops needs a second statistics read at the popped identifier, so the
   // controller goes through the POP state for it. The update is committed together
   // with the loading of the result register, and only when that register is free, so a
   // result that waits downstream lets the next item in but holds its update, and the input
   // stays stalled until the waiting result is taken.
   cdp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // Memory writes land at the commit, ahead of the next acceptance's read, so back to
   // back items on the same identifier always see the updated statistics.
   cdp_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item)
   );

endmodule
